[design/memory_card_serial_responder_assert.svh]
// assertion macros for the memory card serial responder
// used by the top level; no other dependencies
`ifndef MEMORY_CARD_SERIAL_RESPONDER_ASSERT_SVH
`define MEMORY_CARD_SERIAL_RESPONDER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define MCSR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define MCSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/mcsr_pkg.sv]
// shared types and protocol constants of the memory card serial responder
// no dependencies
`timescale 1ns / 1ps

package mcsr_pkg;

   typedef logic [7:0] byte_type;

   // sequencer phases
   typedef enum logic [4:0] {
      PH_ADDRESSING  = 5'd0,
      PH_IGNORED     = 5'd1,
      PH_COMMAND     = 5'd2,
      PH_ID1         = 5'd3,
      PH_ID2         = 5'd4,
      PH_ADDR_MSB    = 5'd5,
      PH_ADDR_LSB    = 5'd6,
      PH_ACK1        = 5'd7,
      PH_ACK2        = 5'd8,
      PH_ECHO_LSB    = 5'd9,
      PH_FIRST_DATA  = 5'd10,
      PH_READ_DATA   = 5'd11,
      PH_READ_STATUS = 5'd12,
      PH_WRITE_DATA  = 5'd13,
      PH_WRITE_CHK   = 5'd14,
      PH_END         = 5'd15
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2
   } kind_type;

   // frame geometry
   localparam int FRAME_BYTES = 128;
   localparam int OFFSET_W    = $clog2(FRAME_BYTES);
   localparam byte_type PTR_LIMIT = 8'(FRAME_BYTES);
   localparam byte_type PTR_LAST  = 8'(FRAME_BYTES - 1);

   // bytes seen on the link
   localparam byte_type ADDR_CARD    = 8'h81;
   localparam byte_type CMD_READ     = 8'h52;
   localparam byte_type CMD_WRITE    = 8'h57;
   localparam byte_type TX_CMD_ACK   = 8'h5A;
   localparam byte_type TX_ID_HI     = 8'h5D;
   localparam byte_type TX_ID_LO     = 8'h5C;
   localparam byte_type TX_ZERO      = 8'h00;
   localparam byte_type TX_GOOD      = 8'h47;
   localparam byte_type TX_BAD       = 8'h4E;
   localparam byte_type TX_IDLE      = 8'hFF;
   localparam byte_type NEW_CARD_BIT = 8'(1 << 3);

endpackage

[design/mcsr_req_if.sv]
// request channel of the memory card serial responder
// depends on mcsr_pkg
`timescale 1ns / 1ps

interface mcsr_req_if;
   logic                valid;
   logic                ready;
   logic                action;
   mcsr_pkg::byte_type  rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

[design/mcsr_rsp_if.sv]
// response channel of the memory card serial responder
// depends on mcsr_pkg
`timescale 1ns / 1ps

interface mcsr_rsp_if;
   logic                valid;
   logic                ready;
   mcsr_pkg::byte_type  tx_byte;
   logic                ack;

   modport source (output valid, output tx_byte, output ack, input ready);
   modport sink (input valid, input tx_byte, input ack, output ready);
endinterface

[design/mcsr_ram.sv]
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mcsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[design/memory_card_serial_responder.sv]
// memory card serial responder: the card side of a byte-exchange serial link
// One request transaction carries an action (0 = exchange one byte, 1 = chip
// select deassert) and the byte received from the host. Each request gives
// exactly one response transaction: the byte sent back and the acknowledge.
// The response is registered and valid in the cycle after its request is
// accepted; while the receiver is ready, one request can be accepted in every
// cycle, so a sustained rate of one transaction per cycle. The rate is set by
// the single registered pass of the sequencer and the one read port of the
// card store, which is read one transaction ahead. Store writes retire through
// write pipeline registers wr1 and wr2, while the frame number is reduced modulo
// FRAME_COUNT by a reciprocal multiply registered in quot_ff, then frame_mod_ff.
// Response register: a request is taken whenever the response register is
// empty or being taken in the same cycle; a stalled receiver holds the
// response and stops request intake.
// Reset (synchronous, active high) returns the sequencer to addressing with
// the new card bit set; the card store is not cleared and holds whatever it
// had until written, so no clearing pass is needed after reset.
// Depends on mcsr_pkg, mcsr_req_if, mcsr_rsp_if, mcsr_ram and the assert header.
`timescale 1ns / 1ps
`include "memory_card_serial_responder_assert.svh"

module memory_card_serial_responder #(
   parameter int FRAME_COUNT = 1024
) (
   input  logic       clock,
   input  logic       reset,
   mcsr_req_if.sink   req_chan,
   mcsr_rsp_if.source rsp_chan
);

   import mcsr_pkg::*;

   localparam int FRAME_W = $clog2(FRAME_COUNT);
   localparam int ADDR_W  = FRAME_W + OFFSET_W;
   localparam int DEPTH   = FRAME_COUNT * FRAME_BYTES;
   localparam logic [16:0] COUNT_K = 17'(FRAME_COUNT);
   localparam logic [16:0] RECIP_K = 17'(65536 / FRAME_COUNT);

   // sequencer state
   phase_type    phase_ff, phase_in;
   kind_type     kind_ff, kind_in;
   logic [15:0]  frame_number_ff, frame_number_in;
   byte_type     byte_pointer_ff, byte_pointer_in;
   byte_type     running_xor_ff, running_xor_in;
   byte_type     host_checksum_ff, host_checksum_in;
   byte_type     previous_rx_ff, previous_rx_in;
   logic         selected_ff, selected_in;
   byte_type     status_flag_ff, status_flag_in;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   byte_type     rsp_tx_ff, rsp_tx_in;
   logic         rsp_ack_ff, rsp_ack_in;

   // frame modulo pipeline
   logic [15:0]        quot_ff, quot_in;
   logic [FRAME_W-1:0] frame_mod_ff, frame_mod_in;
   logic [32:0]        quot_prod;
   logic [32:0]        back_prod;
   logic [15:0]        rem_raw;

   // write pipeline
   logic                wr1_valid_ff, wr2_valid_ff;
   logic                wr_load;
   byte_type            wr1_data_ff, wr2_data_ff;
   logic [OFFSET_W-1:0] wr1_ptr_ff, wr2_ptr_ff;

   logic         req_accept;
   logic         advance;
   byte_type     tx_next;
   byte_type     rx;
   byte_type     rd_data;

   // next phase after a step that completes
   function automatic phase_type next_phase(input phase_type ph, input kind_type kind);
      phase_type nxt;
      nxt = PH_END;
      if (kind == KIND_READ) begin
         case (ph)
            PH_ID1:        nxt = PH_ID2;
            PH_ID2:        nxt = PH_ADDR_MSB;
            PH_ADDR_MSB:   nxt = PH_ADDR_LSB;
            PH_ADDR_LSB:   nxt = PH_ACK1;
            PH_ACK1:       nxt = PH_ACK2;
            PH_ACK2:       nxt = PH_ECHO_LSB;
            PH_ECHO_LSB:   nxt = PH_FIRST_DATA;
            PH_FIRST_DATA: nxt = PH_READ_DATA;
            PH_READ_DATA:  nxt = PH_READ_STATUS;
            default:       nxt = PH_END;
         endcase
      end else begin
         case (ph)
            PH_ID1:        nxt = PH_ID2;
            PH_ID2:        nxt = PH_ADDR_MSB;
            PH_ADDR_MSB:   nxt = PH_ADDR_LSB;
            PH_ADDR_LSB:   nxt = PH_WRITE_DATA;
            PH_WRITE_DATA: nxt = PH_WRITE_CHK;
            PH_WRITE_CHK:  nxt = PH_ACK1;
            PH_ACK1:       nxt = PH_ACK2;
            default:       nxt = PH_END;
         endcase
      end
      return nxt;
   endfunction

   // handshake
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign rx             = req_chan.rx_byte;

   // sequencer next state and response byte
   always_comb begin
      phase_in         = phase_ff;
      kind_in          = kind_ff;
      frame_number_in  = frame_number_ff;
      byte_pointer_in  = byte_pointer_ff;
      running_xor_in   = running_xor_ff;
      host_checksum_in = host_checksum_ff;
      previous_rx_in   = previous_rx_ff;
      selected_in      = selected_ff;
      status_flag_in   = status_flag_ff;
      tx_next          = TX_IDLE;
      advance          = 1'b1;
      wr_load          = 1'b0;
      if (req_accept) begin
         if (req_chan.action) begin
            phase_in       = PH_ADDRESSING;
            selected_in    = 1'b0;
            running_xor_in = TX_ZERO;
         end else begin
            unique case (phase_ff)
               PH_ADDRESSING: begin
                  if (rx == ADDR_CARD) begin
                     phase_in    = PH_COMMAND;
                     selected_in = 1'b1;
                     tx_next     = status_flag_ff;
                  end else begin
                     phase_in = PH_IGNORED;
                  end
                  advance = 1'b0;
               end
               PH_COMMAND: begin
                  tx_next = TX_CMD_ACK;
                  if (rx == CMD_READ) begin
                     kind_in  = KIND_READ;
                     phase_in = PH_ID1;
                  end else if (rx == CMD_WRITE) begin
                     kind_in  = KIND_WRITE;
                     phase_in = PH_ID1;
                  end else begin
                     kind_in = KIND_NONE;
                  end
                  advance = 1'b0;
               end
               PH_ID1: tx_next = TX_ID_HI;
               PH_ID2: tx_next = TX_ZERO;
               PH_ADDR_MSB: begin
                  frame_number_in = {rx, 8'h00};
                  running_xor_in  = running_xor_ff ^ rx;
                  tx_next         = TX_ZERO;
               end
               PH_ADDR_LSB: begin
                  frame_number_in = frame_number_ff | {8'h00, rx};
                  byte_pointer_in = TX_ZERO;
                  running_xor_in  = running_xor_ff ^ rx;
                  tx_next         = (kind_ff == KIND_READ) ? TX_ID_LO : previous_rx_ff;
               end
               PH_ACK1: tx_next = TX_ID_HI;
               PH_ACK2: begin
                  if (kind_ff == KIND_READ) begin
                     tx_next = frame_number_ff[15:8];
                  end else begin
                     status_flag_in = status_flag_ff & ~NEW_CARD_BIT;
                     tx_next = (running_xor_ff == host_checksum_ff) ? TX_GOOD : TX_BAD;
                  end
               end
               PH_ECHO_LSB: tx_next = frame_number_ff[7:0];
               PH_FIRST_DATA: begin
                  tx_next         = rd_data;
                  running_xor_in  = running_xor_ff ^ rd_data;
                  byte_pointer_in = byte_pointer_ff + 8'd1;
               end
               PH_READ_DATA: begin
                  if (byte_pointer_ff < PTR_LIMIT) begin
                     tx_next        = rd_data;
                     running_xor_in = running_xor_ff ^ rd_data;
                  end else begin
                     tx_next = running_xor_ff;
                  end
                  byte_pointer_in = byte_pointer_ff + 8'd1;
                  advance         = byte_pointer_ff >= PTR_LIMIT;
               end
               PH_READ_STATUS: tx_next = TX_GOOD;
               PH_WRITE_DATA: begin
                  if (byte_pointer_ff < PTR_LIMIT) begin
                     wr_load        = 1'b1;
                     running_xor_in = running_xor_ff ^ rx;
                  end
                  byte_pointer_in = byte_pointer_ff + 8'd1;
                  tx_next         = previous_rx_ff;
                  advance         = byte_pointer_ff >= PTR_LAST;
               end
               PH_WRITE_CHK: begin
                  host_checksum_in = rx;
                  tx_next          = TX_ID_LO;
               end
               default: advance = 1'b0;
            endcase
            if (advance) begin
               phase_in = next_phase(phase_ff, kind_ff);
            end
            previous_rx_in = rx;
         end
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_ADDRESSING;
         kind_ff          <= KIND_NONE;
         frame_number_ff  <= '0;
         byte_pointer_ff  <= '0;
         running_xor_ff   <= '0;
         host_checksum_ff <= '0;
         previous_rx_ff   <= '0;
         selected_ff      <= 1'b0;
         status_flag_ff   <= NEW_CARD_BIT;
      end else begin
         phase_ff         <= phase_in;
         kind_ff          <= kind_in;
         frame_number_ff  <= frame_number_in;
         byte_pointer_ff  <= byte_pointer_in;
         running_xor_ff   <= running_xor_in;
         host_checksum_ff <= host_checksum_in;
         previous_rx_ff   <= previous_rx_in;
         selected_ff      <= selected_in;
         status_flag_ff   <= status_flag_in;
      end
   end

   // response register
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_tx_in    = req_accept ? tx_next : rsp_tx_ff;
   assign rsp_ack_in   = req_accept ? selected_in : rsp_ack_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_tx_ff  <= rsp_tx_in;
      rsp_ack_ff <= rsp_ack_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.tx_byte = rsp_tx_ff;
   assign rsp_chan.ack     = rsp_ack_ff;

   // frame number modulo frame count: reciprocal estimate, then one correction
   assign quot_prod = {17'd0, frame_number_ff} * {16'd0, RECIP_K};
   assign quot_in   = quot_prod[31:16];
   assign back_prod = {17'd0, quot_ff} * {16'd0, COUNT_K};
   assign rem_raw   = frame_number_ff - back_prod[15:0];

   always_comb begin
      if ({1'b0, rem_raw} >= COUNT_K) begin
         frame_mod_in = FRAME_W'(rem_raw - COUNT_K[15:0]);
      end else begin
         frame_mod_in = FRAME_W'(rem_raw);
      end
   end

   always_ff @(posedge clock) begin
      quot_ff      <= quot_in;
      frame_mod_ff <= frame_mod_in;
   end

   // write pipeline, waits for the frame modulo to settle
   always_ff @(posedge clock) begin
      if (reset) begin
         wr1_valid_ff <= 1'b0;
         wr2_valid_ff <= 1'b0;
      end else begin
         wr1_valid_ff <= wr_load;
         wr2_valid_ff <= wr1_valid_ff;
      end
      wr1_data_ff <= rx;
      wr1_ptr_ff  <= byte_pointer_ff[OFFSET_W-1:0];
      wr2_data_ff <= wr1_data_ff;
      wr2_ptr_ff  <= wr1_ptr_ff;
   end

   // card store, read one transaction ahead at the next byte pointer
   mcsr_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr2_valid_ff),
      .wr_addr (ADDR_W'({frame_mod_ff, wr2_ptr_ff})),
      .wr_data (wr2_data_ff),
      .rd_en   (req_accept),
      .rd_addr (ADDR_W'({frame_mod_ff, byte_pointer_in[OFFSET_W-1:0]})),
      .rd_data (rd_data)
   );

   // checks
   `MCSR_ASSERT_NOW(a_no_accept_on_stall, clock, reset, rsp_valid_ff && !rsp_chan.ready, !req_accept, "request taken while response stalled")
   `MCSR_ASSERT_NEXT(a_deselect_response, clock, reset, req_accept && req_chan.action, rsp_valid_ff && !rsp_ack_ff && (rsp_tx_ff == TX_IDLE), "deselect response wrong")
   `MCSR_ASSERT_NOW(a_unselected_phase, clock, reset, !selected_ff, (phase_ff == PH_ADDRESSING) || (phase_ff == PH_IGNORED), "sequencer active while not selected")

endmodule

[verif/testbench.sv]
// self-checking testbench for the memory card serial responder
// drives byte transactions, predicts each reply from its own card model
// depends on mcsr_pkg, mcsr_req_if, mcsr_rsp_if and memory_card_serial_responder
`timescale 1ns / 1ps

module testbench;
   import mcsr_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 5;
   localparam int CARD_FRAMES  = 1024;
   localparam int RANDOM_BYTES = 450;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int READ_REPLY_BYTES = FRAME_BYTES + 5;

   typedef struct packed {
      byte_type tx_byte;
      logic     ack;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcsr_req_if req_bus ();
   mcsr_rsp_if rsp_bus ();

   memory_card_serial_responder #(
      .FRAME_COUNT(CARD_FRAMES)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // card model state
   phase_type   card_phase = PH_ADDRESSING;
   kind_type    card_kind = KIND_NONE;
   logic [15:0] frame_no = '0;
   byte_type    data_ptr = '0;
   byte_type    link_xor = '0;
   byte_type    host_sum = '0;
   byte_type    last_rx = '0;
   logic        card_selected = 1'b0;
   byte_type    card_flag = NEW_CARD_BIT;
   byte_type    card_image [int unsigned];

   reply_type   pending_replies[$];
   int unsigned ready_frames[$];
   int          mismatch_count = 0;
   int          counted_bytes = 0;
   int          calm_items = 0;
   int          cycle_count = 0;
   bit          gaps_on = 1'b1;
   bit          stalls_on = 1'b1;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // location of one byte in the card image
   function automatic int unsigned store_slot(input logic [15:0] frame, input byte_type ptr);
      return (32'(frame) % CARD_FRAMES) * FRAME_BYTES + (32'(ptr) % FRAME_BYTES);
   endfunction

   // advance the card model by one transaction and give its reply
   function automatic void predict_card_reply(input logic deselect, input byte_type rx,
                                              output reply_type reply);
      logic     advance;
      byte_type tx;
      tx = TX_IDLE;
      advance = 1'b1;
      if (deselect) begin
         card_phase = PH_ADDRESSING;
         card_selected = 1'b0;
         link_xor = '0;
         reply.tx_byte = TX_IDLE;
         reply.ack = 1'b0;
      end else begin
         case (card_phase)
            PH_ADDRESSING: begin
               if (rx == ADDR_CARD) begin
                  card_phase = PH_COMMAND;
                  card_selected = 1'b1;
                  tx = card_flag;
               end else begin
                  card_phase = PH_IGNORED;
               end
               advance = 1'b0;
            end
            PH_COMMAND: begin
               tx = TX_CMD_ACK;
               if (rx == CMD_READ) begin
                  card_kind = KIND_READ;
                  card_phase = PH_ID1;
               end else if (rx == CMD_WRITE) begin
                  card_kind = KIND_WRITE;
                  card_phase = PH_ID1;
               end else begin
                  card_kind = KIND_NONE;
               end
               advance = 1'b0;
            end
            PH_ID1: tx = TX_ID_HI;
            PH_ID2: tx = TX_ZERO;
            PH_ADDR_MSB: begin
               frame_no = {rx, 8'h00};
               link_xor ^= rx;
               tx = TX_ZERO;
            end
            PH_ADDR_LSB: begin
               frame_no = frame_no | 16'(rx);
               data_ptr = '0;
               link_xor ^= rx;
               tx = (card_kind == KIND_READ) ? TX_ID_LO : last_rx;
            end
            PH_ACK1: tx = TX_ID_HI;
            PH_ACK2: begin
               if (card_kind == KIND_READ) begin
                  tx = frame_no[15:8];
               end else begin
                  card_flag = card_flag & ~NEW_CARD_BIT;
                  tx = (link_xor == host_sum) ? TX_GOOD : TX_BAD;
               end
            end
            PH_ECHO_LSB: tx = frame_no[7:0];
            PH_FIRST_DATA: begin
               tx = card_image[store_slot(frame_no, data_ptr)];
               link_xor ^= tx;
               data_ptr++;
            end
            PH_READ_DATA: begin
               if (data_ptr < PTR_LIMIT) begin
                  tx = card_image[store_slot(frame_no, data_ptr)];
                  link_xor ^= tx;
               end else begin
                  tx = link_xor;
               end
               data_ptr++;
               advance = (data_ptr > PTR_LIMIT);
            end
            PH_READ_STATUS: tx = TX_GOOD;
            PH_WRITE_DATA: begin
               if (data_ptr < PTR_LIMIT) begin
                  card_image[store_slot(frame_no, data_ptr)] = rx;
                  link_xor ^= rx;
               end
               data_ptr++;
               tx = last_rx;
               advance = (data_ptr >= PTR_LIMIT);
            end
            PH_WRITE_CHK: begin
               host_sum = rx;
               tx = TX_ID_LO;
            end
            default: advance = 1'b0;
         endcase
         // sequencer walk, read and write orders differ
         if (advance) begin
            if (card_kind == KIND_READ) begin
               case (card_phase)
                  PH_ID1:        card_phase = PH_ID2;
                  PH_ID2:        card_phase = PH_ADDR_MSB;
                  PH_ADDR_MSB:   card_phase = PH_ADDR_LSB;
                  PH_ADDR_LSB:   card_phase = PH_ACK1;
                  PH_ACK1:       card_phase = PH_ACK2;
                  PH_ACK2:       card_phase = PH_ECHO_LSB;
                  PH_ECHO_LSB:   card_phase = PH_FIRST_DATA;
                  PH_FIRST_DATA: card_phase = PH_READ_DATA;
                  PH_READ_DATA:  card_phase = PH_READ_STATUS;
                  default:       card_phase = PH_END;
               endcase
            end else begin
               case (card_phase)
                  PH_ID1:        card_phase = PH_ID2;
                  PH_ID2:        card_phase = PH_ADDR_MSB;
                  PH_ADDR_MSB:   card_phase = PH_ADDR_LSB;
                  PH_ADDR_LSB:   card_phase = PH_WRITE_DATA;
                  PH_WRITE_DATA: card_phase = PH_WRITE_CHK;
                  PH_WRITE_CHK:  card_phase = PH_ACK1;
                  PH_ACK1:       card_phase = PH_ACK2;
                  default:       card_phase = PH_END;
               endcase
            end
         end
         last_rx = rx;
         reply.tx_byte = tx;
         reply.ack = card_selected;
      end
   endfunction

   // send one transaction and record the reply it should cause
   task automatic send_item(input logic deselect, input byte_type rx);
      logic      act;
      bit        filled;
      int        gap;
      reply_type reply;
      act = deselect;
      // a read may only target a frame whose bytes were all written
      if (!act && card_kind == KIND_READ && card_phase == PH_ADDR_LSB) begin
         filled = 1'b1;
         for (int i = 0; i < FRAME_BYTES; i++) begin
            if (!card_image.exists(store_slot(frame_no | 16'(rx), 8'(i))))
               filled = 1'b0;
         end
         if (!filled)
            act = 1'b1;
      end
      // sender gaps, with calm stretches in between
      if (calm_items > 0)
         calm_items--;
      else if ($urandom_range(0, 15) == 0)
         calm_items = $urandom_range(10, 60);
      if (gaps_on && calm_items == 0 && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.rx_byte <= rx;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (card_phase != PH_IGNORED)
         counted_bytes++;
      predict_card_reply(act, rx, reply);
      pending_replies.push_back(reply);
   endtask

   // deselect, then the byte list, then deselect; cut_at aborts early
   task automatic play_sequence(input byte_type link_bytes[$], input int cut_at);
      send_item(1'b1, 8'($urandom_range(0, 255)));
      foreach (link_bytes[i]) begin
         if (i == cut_at) begin
            send_item(1'b1, 8'($urandom_range(0, 255)));
            return;
         end
         send_item(1'b0, link_bytes[i]);
      end
      send_item(1'b1, 8'($urandom_range(0, 255)));
   endtask

   task automatic run_write(input logic [15:0] frame, input bit bad_sum, input int cut_at);
      byte_type link_bytes[$];
      byte_type link_sum;
      byte_type data;
      link_bytes.push_back(ADDR_CARD);
      link_bytes.push_back(CMD_WRITE);
      link_bytes.push_back(8'($urandom_range(0, 255)));
      link_bytes.push_back(8'($urandom_range(0, 255)));
      link_bytes.push_back(frame[15:8]);
      link_bytes.push_back(frame[7:0]);
      link_sum = frame[15:8] ^ frame[7:0];
      repeat (FRAME_BYTES) begin
         data = 8'($urandom_range(0, 255));
         link_bytes.push_back(data);
         link_sum ^= data;
      end
      if (bad_sum)
         link_sum ^= 8'($urandom_range(1, 255));
      link_bytes.push_back(link_sum);
      // acknowledge bytes, then a few past the end of the sequence
      repeat (2 + $urandom_range(1, 3))
         link_bytes.push_back(8'($urandom_range(0, 255)));
      play_sequence(link_bytes, cut_at);
      if (cut_at < 0)
         ready_frames.push_back(32'(frame) % CARD_FRAMES);
   endtask

   task automatic run_read(input logic [15:0] frame, input int cut_at);
      byte_type link_bytes[$];
      link_bytes.push_back(ADDR_CARD);
      link_bytes.push_back(CMD_READ);
      link_bytes.push_back(8'($urandom_range(0, 255)));
      link_bytes.push_back(8'($urandom_range(0, 255)));
      link_bytes.push_back(frame[15:8]);
      link_bytes.push_back(frame[7:0]);
      repeat (READ_REPLY_BYTES + $urandom_range(1, 3))
         link_bytes.push_back(8'($urandom_range(0, 255)));
      play_sequence(link_bytes, cut_at);
   endtask

   // any frame number that lands on a fully written frame
   function automatic logic [15:0] written_frame();
      int unsigned base;
      base = ready_frames[$urandom_range(0, ready_frames.size() - 1)];
      return 16'(base + CARD_FRAMES * $urandom_range(0, 65536 / CARD_FRAMES - 1));
   endfunction

   function automatic logic [15:0] any_frame();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic byte_type noise_byte();
      case ($urandom_range(0, 7))
         0, 1:    return ADDR_CARD;
         2:       return CMD_READ;
         3:       return CMD_WRITE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // address filtering, unknown commands, deselect in mid-write, guarded read
   task automatic test_link_corners();
      send_item(1'b1, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, ADDR_CARD);
      send_item(1'b0, 8'hFF);
      send_item(1'b1, 8'hFF);
      send_item(1'b0, ADDR_CARD);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, ADDR_CARD);
      send_item(1'b0, CMD_WRITE);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'h5A);
      send_item(1'b1, 8'h00);
      send_item(1'b0, ADDR_CARD);
      send_item(1'b0, CMD_READ);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, 8'hFF);
   endtask

   // full writes through frame numbers above the frame count, one with a bad checksum
   task automatic test_frame_writes();
      run_write(16'h8000, 1'b0, -1);
      run_write(16'hFFFF, 1'b0, -1);
      run_write(16'h0401, 1'b1, -1);
   endtask

   // read back, partly through aliased frame numbers
   task automatic test_frame_reads();
      run_read(16'h0000, -1);
      run_read(16'hFFFF, -1);
      run_read(16'h0401, -1);
   endtask

   task automatic test_broken_sequences();
      repeat (4) begin
         if ($urandom_range(0, 1) == 0)
            run_write(any_frame(), $urandom_range(0, 1), $urandom_range(0, 140));
         else
            run_read(($urandom_range(0, 1) == 0) ? written_frame() : any_frame(),
                     $urandom_range(0, 140));
      end
   endtask

   // mostly well-formed sequences, with noise and aborted ones mixed in
   task automatic test_random_traffic();
      int start_count;
      int pick;
      start_count = counted_bytes;
      while (counted_bytes - start_count < RANDOM_BYTES) begin
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            run_write(any_frame(), ($urandom_range(0, 4) == 0), -1);
         end else if (pick <= 6) begin
            run_read(written_frame(), -1);
         end else if (pick == 7) begin
            if ($urandom_range(0, 1) == 0)
               run_write(any_frame(), $urandom_range(0, 1), $urandom_range(0, 140));
            else
               run_read(written_frame(), $urandom_range(0, 140));
         end else begin
            repeat ($urandom_range(5, 30))
               send_item(($urandom_range(0, 7) == 0), noise_byte());
         end
      end
   endtask

   // back-to-back transactions with neither side idling
   task automatic test_steady_stream();
      logic [15:0] frame;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      frame = any_frame();
      run_write(frame, 1'b0, -1);
      run_read(frame, -1);
   endtask

   // receiver stalls in bursts, with long ready stretches
   always begin : drive_rsp_ready
      int hold;
      if (stalls_on && $urandom_range(0, 5) == 0) begin
         hold = $urandom_range(1, 12);
         repeat (hold) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
      end else begin
         hold = $urandom_range(1, 40);
         repeat (hold) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // compare each reply transaction with the oldest prediction
   always @(posedge clock) begin : check_replies
      reply_type due;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected reply: expected none, actual tx_byte %h ack %b",
                     $time, rsp_bus.tx_byte, rsp_bus.ack);
         end else begin
            due = pending_replies.pop_front();
            if (rsp_bus.tx_byte !== due.tx_byte) begin
               mismatch_count++;
               $display("%0t tx_byte mismatch: expected %h, actual %h",
                        $time, due.tx_byte, rsp_bus.tx_byte);
            end
            if (rsp_bus.ack !== due.ack) begin
               mismatch_count++;
               $display("%0t ack mismatch: expected %b, actual %b",
                        $time, due.ack, rsp_bus.ack);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.action = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_link_corners();
      test_frame_writes();
      test_frame_reads();
      test_broken_sequences();
      test_random_traffic();
      test_steady_stream();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
